FILE: rtl/cte_pkg.sv
package cte_pkg;

  localparam logic [2:0] CMD_LOOKUP  = 3'd0;
  localparam logic [2:0] CMD_CHECK   = 3'd1;
  localparam logic [2:0] CMD_ADD     = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_SET_PIN = 3'd4;
  localparam logic [2:0] CMD_BLOCK   = 3'd5;
  localparam logic [2:0] CMD_UNBLOCK = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [63:0] id;
    logic [31:0] pin;
    logic        admin;
    logic        blocked;
  } entry_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic       pin_match;
    logic       is_admin;
    logic       is_blocked;
  } rsp_t;

endpackage

FILE: rtl/credential_table_engine.sv
// Channel   Handshake               Payload
// request   req_valid / req_ready   command, user_id, pin_code, entry_index,
//                                   admin_flag, blocked_flag
// response  rsp_valid / rsp_ready   status, found_index, pin_match, is_admin,
//                                   is_blocked, entry_count
//
// One request is in progress at a time; the entry memory has one read and one write port.
// Add, unused commands and rejected requests go straight to the response; check, set_pin,
// block and unblock first read the indexed entry; lookup reads entries from index 0 up to
// a match or the last live entry; delete then shifts each later entry down, one per cycle.
// Reset clears the live count, the sequencer state and rsp_valid; entry contents are undefined until written.
// A stalled response sits in the output register while the next request is accepted.
module credential_table_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  command,
  input  logic [63:0] user_id,
  input  logic [31:0] pin_code,
  input  logic [3:0]  entry_index,
  input  logic        admin_flag,
  input  logic        blocked_flag,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [3:0]  found_index,
  output logic        pin_match,
  output logic        is_admin,
  output logic        is_blocked,
  output logic [4:0]  entry_count
);
  import cte_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic          res_valid;
  logic          res_ready;
  rsp_t          res;
  logic [4:0]    res_count;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  rsp_t          out_q;

  cte_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cte_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .command      (command),
    .user_id      (user_id),
    .pin_code     (pin_code),
    .entry_index  (entry_index),
    .admin_flag   (admin_flag),
    .blocked_flag (blocked_flag),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .res_count    (res_count),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q       <= res;
      entry_count <= res_count;
    end
  end

  assign status      = out_q.status;
  assign found_index = out_q.found_index;
  assign pin_match   = out_q.pin_match;
  assign is_admin    = out_q.is_admin;
  assign is_blocked  = out_q.is_blocked;

endmodule

FILE: rtl/cte_mem.sv
module cte_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  cte_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output cte_pkg::entry_t  rdata
);
  import cte_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cte_seq.sv
module cte_seq #(
  parameter int MAX_ENTRIES = 16,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [2:0]       command,
  input  logic [63:0]      user_id,
  input  logic [31:0]      pin_code,
  input  logic [3:0]       entry_index,
  input  logic             admin_flag,
  input  logic             blocked_flag,
  output logic             res_valid,
  input  logic             res_ready,
  output cte_pkg::rsp_t    res,
  output logic [4:0]       res_count,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output cte_pkg::entry_t  mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  cte_pkg::entry_t  mem_rdata
);
  import cte_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] count, count_next;
  rsp_t          rsp, rsp_next;
  logic [2:0]    cmd;
  logic [63:0]   uid;
  logic [31:0]   pin;
  logic          idx_ok;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = rsp;
  assign res_count = 5'(count);
  assign idx_ok    = 32'(entry_index) < 32'(count);

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    count_next = count;
    rsp_next   = rsp;
    mem_we     = 1'b0;
    mem_waddr  = ptr;
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          rsp_next   = '0;
          state_next = S_DONE;
          case (command)
            CMD_LOOKUP: begin
              if (count == '0) begin
                rsp_next.status = ST_NOT_FOUND;
              end else begin
                ptr_next   = '0;
                mem_raddr  = '0;
                state_next = S_SCAN;
              end
            end
            CMD_ADD: begin
              if (32'(count) >= MAX_ENTRIES) begin
                rsp_next.status = ST_FULL;
              end else begin
                mem_we                 = 1'b1;
                mem_waddr              = AW'(count);
                mem_wdata              = '{id: user_id, pin: pin_code,
                                           admin: admin_flag, blocked: blocked_flag};
                count_next             = count + 1'b1;
                rsp_next.found_index   = 4'(count);
                rsp_next.is_admin      = admin_flag;
                rsp_next.is_blocked    = blocked_flag;
              end
            end
            CMD_CHECK, CMD_DELETE, CMD_SET_PIN, CMD_BLOCK, CMD_UNBLOCK: begin
              if (!idx_ok) begin
                rsp_next.status = ST_BAD_INDEX;
              end else begin
                ptr_next   = AW'(entry_index);
                mem_raddr  = AW'(entry_index);
                state_next = S_IDX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (mem_rdata.id == uid) begin
          rsp_next.found_index = 4'(ptr);
          rsp_next.is_admin    = mem_rdata.admin;
          rsp_next.is_blocked  = mem_rdata.blocked;
          state_next           = S_DONE;
        end else if (32'(ptr) + 1 >= 32'(count)) begin
          rsp_next.status = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          ptr_next  = ptr + 1'b1;
          mem_raddr = ptr + 1'b1;
        end
      end
      S_IDX: begin
        rsp_next.is_admin   = mem_rdata.admin;
        rsp_next.is_blocked = mem_rdata.blocked;
        state_next          = S_DONE;
        case (cmd)
          CMD_CHECK: begin
            rsp_next.pin_match = (mem_rdata.pin == pin);
          end
          CMD_SET_PIN: begin
            mem_we        = 1'b1;
            mem_wdata.pin = pin;
          end
          CMD_BLOCK: begin
            mem_we              = 1'b1;
            mem_wdata.blocked   = 1'b1;
            rsp_next.is_blocked = 1'b1;
          end
          CMD_UNBLOCK: begin
            mem_we              = 1'b1;
            mem_wdata.blocked   = 1'b0;
            rsp_next.is_blocked = 1'b0;
          end
          CMD_DELETE: begin
            if (32'(ptr) + 1 < 32'(count)) begin
              mem_raddr  = ptr + 1'b1;
              state_next = S_DEL;
            end else begin
              count_next = count - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_DEL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        ptr_next  = ptr + 1'b1;
        if (32'(ptr) + 2 < 32'(count)) begin
          mem_raddr = AW'(32'(ptr) + 2);
        end else begin
          count_next = count - 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    rsp <= rsp_next;
    if (req_valid && req_ready) begin
      cmd <= command;
      uid <= user_id;
      pin <= pin_code;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ENTRIES)
    else $error("live count above table size");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) <= 32'(count)) && (32'(mem_waddr) < MAX_ENTRIES))
    else $error("write outside the live entries");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |->
      (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))
    else $error("live count moved by more than one");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in progress");

endmodule

FILE: verif/credential_table_checker.sv
module credential_table_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [2:0]  command,
  input  logic [63:0] user_id,
  input  logic [31:0] pin_code,
  input  logic [3:0]  entry_index,
  input  logic        admin_flag,
  input  logic        blocked_flag,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [1:0]  status,
  input  logic [3:0]  found_index,
  input  logic        pin_match,
  input  logic        is_admin,
  input  logic        is_blocked,
  input  logic [4:0]  entry_count,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import cte_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic       pin_match;
    logic       is_admin;
    logic       is_blocked;
    logic [4:0] entry_count;
  } outcome_t;

  entry_t      card_table [TABLE_DEPTH];
  int unsigned live_entries;
  outcome_t    awaited_outcomes [$];
  int          response_number;

  function automatic outcome_t apply_request(input logic [2:0] cmd, input logic [63:0] uid,
                                             input logic [31:0] pin, input logic [3:0] idx,
                                             input logic adm, input logic blk);
    outcome_t o;
    bit       hit;
    int       i;
    o = '0;
    hit = 1'b0;
    case (cmd)
      CMD_LOOKUP: begin
        o.status = ST_NOT_FOUND;
        for (i = 0; i < live_entries; i++) begin
          if (!hit && card_table[i].id == uid) begin
            hit = 1'b1;
            o.status = ST_OK;
            o.found_index = i[3:0];
            o.is_admin = card_table[i].admin;
            o.is_blocked = card_table[i].blocked;
          end
        end
      end
      CMD_ADD: begin
        if (live_entries >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          card_table[live_entries] = '{id: uid, pin: pin, admin: adm, blocked: blk};
          o.found_index = live_entries[3:0];
          o.is_admin = adm;
          o.is_blocked = blk;
          live_entries++;
        end
      end
      CMD_CHECK, CMD_DELETE, CMD_SET_PIN, CMD_BLOCK, CMD_UNBLOCK: begin
        if (idx >= live_entries || idx >= TABLE_DEPTH) begin
          o.status = ST_BAD_INDEX;
        end else begin
          o.is_admin = card_table[idx].admin;
          o.is_blocked = card_table[idx].blocked;
          case (cmd)
            CMD_CHECK: begin
              o.pin_match = (card_table[idx].pin == pin);
            end
            CMD_DELETE: begin
              for (i = idx; i + 1 < live_entries; i++) begin
                card_table[i] = card_table[i + 1];
              end
              live_entries--;
            end
            CMD_SET_PIN: begin
              card_table[idx].pin = pin;
            end
            CMD_BLOCK: begin
              card_table[idx].blocked = 1'b1;
              o.is_blocked = 1'b1;
            end
            default: begin
              card_table[idx].blocked = 1'b0;
              o.is_blocked = 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    o.entry_count = live_entries[4:0];
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      live_entries = 0;
      awaited_outcomes.delete();
    end else begin
      // A response always belongs to an earlier request, so it is retired first.
      if (rsp_valid && rsp_ready) begin
        got = {status, found_index, pin_match, is_admin, is_blocked, entry_count};
        response_number++;
        if (awaited_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("response %0d arrived with no request waiting for it", response_number);
          end
        end else begin
          want = awaited_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("response %0d: expected status %0d index %0d pin %b adm %b blk %b cnt %0d",
                       response_number, want.status, want.found_index, want.pin_match,
                       want.is_admin, want.is_blocked, want.entry_count);
              $display("response %0d: actual   status %0d index %0d pin %b adm %b blk %b cnt %0d",
                       response_number, got.status, got.found_index, got.pin_match,
                       got.is_admin, got.is_blocked, got.entry_count);
            end
          end
        end
      end
      if (req_valid && req_ready) begin
        awaited_outcomes.push_back(apply_request(command, user_id, pin_code, entry_index,
                                                 admin_flag, blocked_flag));
      end
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

FILE: verif/credential_table_engine_test.sv
module credential_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cte_pkg::*;

  localparam int         TABLE_DEPTH     = 16;
  localparam int         RANDOM_REQUESTS = 1700;
  localparam int         BLOCK_REQUESTS  = 100;
  localparam int         WATCHDOG_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES    = 40;
  localparam logic [2:0] CMD_UNUSED      = 3'd7;

  typedef enum int { FILL_UP, DRAIN_DOWN, CHURN } mix_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [2:0]  command;
  logic [63:0] user_id;
  logic [31:0] pin_code;
  logic [3:0]  entry_index;
  logic        admin_flag;
  logic        blocked_flag;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  found_index;
  logic        pin_match;
  logic        is_admin;
  logic        is_blocked;
  logic [4:0]  entry_count;
  int          mismatches;
  int          outstanding;

  bit          idling_on = 1'b1;
  int          stall_left;
  int          quiet_cycles;
  int          table_fill;
  logic [63:0] id_pool [16];
  logic [31:0] pin_pool [8];

  always #1 clk = ~clk;

  credential_table_engine #(.MAX_ENTRIES(TABLE_DEPTH)) dut (.*);

  credential_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [63:0] uid,
                              input logic [31:0] pin, input logic [3:0] idx,
                              input logic adm, input logic blk);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    user_id <= uid;
    pin_code <= pin;
    entry_index <= idx;
    admin_flag <= adm;
    blocked_flag <= blk;
    do @(posedge clk); while (!req_ready);
    if (cmd == CMD_ADD && table_fill < TABLE_DEPTH) table_fill++;
    if (cmd == CMD_DELETE && idx < table_fill) table_fill--;
    @(negedge clk);
  endtask

  task automatic random_request(input mix_t mix);
    int          add_pct;
    int          delete_pct;
    int          roll;
    int          pick;
    logic [2:0]  cmd;
    logic [63:0] uid;
    logic [31:0] pin;
    logic [3:0]  idx;
    case (mix)
      FILL_UP: begin
        add_pct = 50;
        delete_pct = 5;
      end
      DRAIN_DOWN: begin
        add_pct = 10;
        delete_pct = 40;
      end
      default: begin
        add_pct = 25;
        delete_pct = 20;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      cmd = CMD_ADD;
    end else if (roll < add_pct + delete_pct) begin
      cmd = CMD_DELETE;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 8) cmd = CMD_LOOKUP;
      else if (pick < 11) cmd = CMD_CHECK;
      else if (pick < 14) cmd = CMD_SET_PIN;
      else if (pick < 16) cmd = CMD_BLOCK;
      else if (pick < 18) cmd = CMD_UNBLOCK;
      else if (pick < 19) cmd = CMD_UNUSED;
      else cmd = CMD_CHECK;
    end
    // Reused IDs give lookup hits and duplicate entries; reused PINs give matches.
    if ($urandom_range(0, 9) < 8) uid = id_pool[$urandom_range(0, 15)];
    else uid = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 6) pin = pin_pool[$urandom_range(0, 7)];
    else pin = $urandom;
    if (table_fill > 0 && $urandom_range(0, 9) != 0) begin
      idx = 4'($urandom_range(0, table_fill - 1));
    end else begin
      idx = 4'($urandom_range(0, 15));
    end
    send_request(cmd, uid, pin, idx, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int   blk_num;
    int   n;
    mix_t mix;
    rst = 1'b1;
    req_valid = 1'b0;
    command = CMD_LOOKUP;
    user_id = '0;
    pin_code = '0;
    entry_index = '0;
    admin_flag = 1'b0;
    blocked_flag = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (n = 2; n < 16; n++) id_pool[n] = {$urandom, $urandom};
    pin_pool[0] = '0;
    pin_pool[1] = '1;
    for (n = 2; n < 8; n++) pin_pool[n] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(CMD_LOOKUP, '0, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_CHECK, '0, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_DELETE, '0, '0, 4'd15, 1'b0, 1'b0);
    send_request(CMD_ADD, '1, '1, 4'd0, 1'b1, 1'b1);
    send_request(CMD_ADD, '0, '0, 4'd15, 1'b0, 1'b0);
    send_request(CMD_ADD, 64'h0123_4567_89AB_CDEF, 32'h8000_0001, 4'd0, 1'b1, 1'b0);
    send_request(CMD_ADD, '1, 32'h0000_0005, 4'd0, 1'b0, 1'b1);
    send_request(CMD_LOOKUP, '1, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_LOOKUP, '0, '1, 4'd15, 1'b1, 1'b1);
    send_request(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_CHECK, '0, '1, 4'd0, 1'b0, 1'b0);
    send_request(CMD_CHECK, '0, 32'h0000_0001, 4'd1, 1'b0, 1'b0);
    send_request(CMD_SET_PIN, '0, 32'hDEAD_BEEF, 4'd1, 1'b0, 1'b0);
    send_request(CMD_CHECK, '0, 32'hDEAD_BEEF, 4'd1, 1'b0, 1'b0);
    send_request(CMD_BLOCK, '0, '0, 4'd1, 1'b0, 1'b0);
    send_request(CMD_UNBLOCK, '0, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_SET_PIN, '0, '1, 4'd4, 1'b0, 1'b0);
    send_request(CMD_BLOCK, '0, '0, 4'd15, 1'b0, 1'b0);
    send_request(CMD_UNUSED, '1, '1, 4'd15, 1'b1, 1'b1);
    send_request(CMD_DELETE, '0, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_LOOKUP, '1, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_DELETE, '0, '0, 4'd2, 1'b0, 1'b0);
    send_request(CMD_UNBLOCK, '0, '0, 4'd1, 1'b0, 1'b0);
    send_request(CMD_DELETE, '0, '0, 4'd0, 1'b0, 1'b0);
    send_request(CMD_DELETE, '0, '0, 4'd0, 1'b0, 1'b0);

    // Each block has its own mix; every third block and the last two run with no idling at all.
    for (blk_num = 0; blk_num < RANDOM_REQUESTS / BLOCK_REQUESTS; blk_num++) begin
      mix = mix_t'($urandom_range(0, 2));
      idling_on = (blk_num % 3 != 2) && (blk_num < RANDOM_REQUESTS / BLOCK_REQUESTS - 2);
      for (n = 0; n < BLOCK_REQUESTS; n++) random_request(mix);
    end
    req_valid <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cte_pkg.sv
rtl/cte_mem.sv
rtl/cte_seq.sv
rtl/credential_table_engine.sv
verif/credential_table_checker.sv
verif/credential_table_engine_test.sv
